>>> hdl/trdpt_pkg.sv
package trdpt_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_NEXT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

>>> hdl/trial_division_prime_test_top.sv
// Trial-division primality test. Each input word carries one signed VALUE_WIDTH-bit
// integer and yields one output word with is_prime set when the integer is prime.
// Negative values, zero and one go straight to the result. Otherwise divisors d = 2, 3, ...
// are tried while d*d <= value; each divisor takes one bound check, VALUE_WIDTH - 1 steps
// of a bit-serial restoring remainder unit, then a zero remainder ends the test with
// is_prime clear, else d and d*d are updated. Most of the run time is set by the serial
// remainder unit.
// One item is in flight at a time: in_stall stays high from acceptance until the
// result word has been taken.
module trial_division_prime_test_top
  import trdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_prime
);

  localparam int MW = VALUE_WIDTH - 1;
  localparam int DW = VALUE_WIDTH / 2 + 2;
  localparam int SW = VALUE_WIDTH + 1;
  localparam int CW = $clog2(MW);

  state_t          state_r, state_nxt;
  logic [MW-1:0]   mag_r, mag_nxt;
  logic [DW-1:0]   div_r, div_nxt;
  logic [SW-1:0]   sq_r, sq_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   bit_r, bit_nxt;
  logic            prime_r, prime_nxt;

  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            rem_ge;
  logic            sq_le;

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = (state_r == ST_DONE);
  assign out_is_prime = prime_r;

  assign rem_sh  = {rem_r, mag_r[bit_r]};
  assign rem_ge  = (rem_sh >= {1'b0, div_r});
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign sq_le   = (sq_r <= {{(SW-MW){1'b0}}, mag_r});

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    prime_nxt = prime_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mag_nxt = in_value[MW-1:0];
          div_nxt = DW'(2);
          sq_nxt  = SW'(4);
          if (in_value[VALUE_WIDTH-1] || (in_value[MW-1:0] < MW'(2))) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_le) begin
          rem_nxt   = '0;
          bit_nxt   = CW'(MW - 1);
          state_nxt = ST_DIV;
        end else begin
          prime_nxt = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        if (bit_r == '0) begin
          state_nxt = ST_NEXT;
        end else begin
          bit_nxt = bit_r - CW'(1);
        end
      end
      ST_NEXT: begin
        if (rem_r == '0) begin
          prime_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          // (d+1)^2 = d^2 + 2d + 1
          sq_nxt    = sq_r + {{(SW-DW-1){1'b0}}, div_r, 1'b1};
          div_nxt   = div_r + DW'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    prime_r <= prime_nxt;
  end

endmodule
